// ===== src/oversampled_line_code_decoder_core_assert.svh =====
// Assertion macros for the oversampled line-code decoder.
// Expects clk and rst in scope at the point of use.
`ifndef OVERSAMPLED_LINE_CODE_DECODER_CORE_ASSERT_SVH
`define OVERSAMPLED_LINE_CODE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OLCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/olcd_pkg.sv =====
// Shared types and constants for the oversampled line-code decoder.
// No dependencies.
package olcd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int WINDOW_WIDTH_DEF = 10;

  localparam int MODE_W   = 2;
  localparam int THRESH_W = 12;
  localparam int SPB_W    = 10;
  localparam int DUTY_W   = 8;
  localparam int CFG_DW   = 12;
  localparam int CFG_AW   = 2;
  localparam int INDEX_W  = 16;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_THRESH = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SPB    = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DUTY   = 2'd3;

  // mode bits: bit 1 selects RZ, bit 0 selects NRZI among level modes
  localparam int MODE_NRZI_BIT = 0;
  localparam int MODE_RZ_BIT   = 1;

  localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
  localparam logic [THRESH_W-1:0] THRESH_RST = 12'd2048;
  localparam logic [SPB_W-1:0]    SPB_RST    = 10'd10;
  localparam logic [DUTY_W-1:0]   DUTY_RST   = 8'd128;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [THRESH_W-1:0] level_threshold;
    logic [SPB_W-1:0]    window_len;
    logic [DUTY_W-1:0]   duty_ratio_q8;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic               bit_res;
    logic [INDEX_W-1:0] bit_index;
  } res_t;

endpackage

// ===== src/olcd_cfg.sv =====
// Configuration register file for the line-code decoder.
// Depends on olcd_pkg.
module olcd_cfg import olcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_RST;
      cfg.level_threshold <= THRESH_RST;
      cfg.window_len      <= SPB_RST;
      cfg.duty_ratio_q8   <= DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:   cfg.mode            <= cfg_wdata[MODE_W-1:0];
        REG_THRESH: cfg.level_threshold <= cfg_wdata[THRESH_W-1:0];
        REG_SPB:    cfg.window_len      <= cfg_wdata[SPB_W-1:0];
        REG_DUTY:   cfg.duty_ratio_q8   <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/olcd_window.sv =====
// Window tally, frame state and bit decision for one registered sample.
// Depends on olcd_pkg and the assertion macro header.
`include "oversampled_line_code_decoder_core_assert.svh"

module olcd_window import olcd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    adv,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    in_last,
  output res_t                    res
);

  localparam int CMP_W  = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
  localparam int PROD_W = WINDOW_WIDTH + DUTY_W;

  logic [WINDOW_WIDTH-1:0] window_position, window_position_next;
  logic [WINDOW_WIDTH-1:0] high_tally, high_tally_next;
  logic                    previous_level, previous_level_next;
  logic                    frame_begin, frame_begin_next;
  logic [INDEX_W-1:0]      bit_counter, bit_counter_next;

  logic                    rz, nrzi, hi, ref_only, close, level, rz_bit;
  logic [WINDOW_WIDTH-1:0] spb_raw, spb, pos, tally;
  logic [PROD_W-1:0]       duty_prod, tally_scaled;
  logic                    window_clear, frame_clear;

  assign rz   = cfg.mode[MODE_RZ_BIT];
  assign nrzi = cfg.mode[MODE_NRZI_BIT];
  assign hi   = CMP_W'(in_sample) > CMP_W'(cfg.level_threshold);

  assign spb_raw = WINDOW_WIDTH'(cfg.window_len);
  // zero window length acts as one
  assign spb     = (spb_raw == '0) ? WINDOW_WIDTH'(1) : spb_raw;

  assign pos   = window_position + WINDOW_WIDTH'(1);
  assign tally = high_tally + WINDOW_WIDTH'(hi);
  assign close = (pos >= spb) || (pos == '0);

  // first sample of a level-coded frame only sets the reference
  assign ref_only = frame_begin && !rz;

  assign level        = {tally, 1'b0} > {1'b0, spb};
  assign duty_prod    = PROD_W'(cfg.duty_ratio_q8) * PROD_W'(spb);
  assign tally_scaled = {tally, 8'b0};
  assign rz_bit       = tally_scaled > duty_prod;

  always_comb begin
    window_position_next = window_position;
    high_tally_next      = high_tally;
    previous_level_next  = previous_level;
    frame_begin_next     = 1'b0;
    bit_counter_next     = bit_counter;
    res.emit             = 1'b0;
    res.bit_res          = rz ? rz_bit : (nrzi ? (level ^ previous_level) : level);
    res.bit_index        = bit_counter;

    if (ref_only) begin
      previous_level_next = hi;
    end else if (close) begin
      res.emit             = 1'b1;
      if (!rz) previous_level_next = level;
      bit_counter_next     = bit_counter + INDEX_W'(1);
      window_position_next = '0;
      high_tally_next      = '0;
    end else begin
      window_position_next = pos;
      high_tally_next      = tally;
    end

    if (in_last) begin
      window_position_next = '0;
      high_tally_next      = '0;
      bit_counter_next     = '0;
      frame_begin_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_position <= '0;
      high_tally      <= '0;
      previous_level  <= 1'b0;
      frame_begin     <= 1'b1;
      bit_counter     <= '0;
    end else if (adv) begin
      window_position <= window_position_next;
      high_tally      <= high_tally_next;
      previous_level  <= previous_level_next;
      frame_begin     <= frame_begin_next;
      bit_counter     <= bit_counter_next;
    end
  end

  assign window_clear = (window_position == '0) && (high_tally == '0);
  assign frame_clear  = frame_begin && (bit_counter == '0) && (window_position == '0);

  `OLCD_ASSERT_SAME(a_tally_le_pos, 1'b1, high_tally <= window_position, "tally above position")
  `OLCD_ASSERT_NEXT(a_frame_end, adv && in_last, frame_clear, "frame end did not clear state")
  `OLCD_ASSERT_NEXT(a_emit_clears, adv && res.emit, window_clear, "window not restarted after bit")

endmodule

// ===== src/oversampled_line_code_decoder_core.sv =====
// Top level of the line-code decoder; uses olcd_pkg, olcd_cfg and olcd_window.
// A bit is valid on m_tdata once the sample closing its window has passed the input and result registers.
// Throughput: one sample per cycle; a full window yields one bit; a held result stalls input.
// The window counter and tally update once per accepted sample, which sets the rate.
// Reset (rst, synchronous): config to NRZ, threshold 2048, 10 samples/bit, duty 128;
// window cleared, frame awaiting its first sample, both stream registers empty.
module oversampled_line_code_decoder_core import olcd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // [SAMPLE_WIDTH-1:0] sample
  input  logic                  s_tlast,   // last_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [0] bit_res, [16:1] bit_index
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_DW-1:0]     cfg_wdata
);

  cfg_t                    cfg;
  res_t                    res;
  logic                    in_valid, in_last, adv;
  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic                    out_bit;
  logic [INDEX_W-1:0]      out_index;

  olcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // item in the input register is processed once the result register has room
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_WIDTH-1:0];
      in_last   <= s_tlast;
    end
  end

  olcd_window #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .adv       (adv),
    .in_sample (in_sample),
    .in_last   (in_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      out_bit   <= res.bit_res;
      out_index <= res.bit_index;
    end
  end

  assign m_tdata = {7'b0, out_index, out_bit};

endmodule
